FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property under clock and active-low reset.
`define WST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define WST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/wst_pkg.sv
// Types and constants of the weighted sum-tree selector.
// No dependencies; used by wst_alu, the top level and the checker.
`timescale 1ns / 1ps

package wst_pkg;

	// Field widths.
	localparam int NODE_W   = 29;
	localparam int WEIGHT_W = 23;
	localparam int SUM_W    = 30;
	localparam int RAW_W    = 16;
	localparam int RND_W    = 32;
	localparam int IDX_W    = 6;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int DIV_CNT_W = $clog2(RND_W);

	// The weight scale of one hundred is built as 64 + 32 + 4.
	localparam int SCALE_SH_A = 6;
	localparam int SCALE_SH_B = 5;
	localparam int SCALE_SH_C = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_SELECT = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_SELECTED = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic [SUM_W-1:0]   a;
		logic [SUM_W-1:0]   b;
	} alu_req_t;

	typedef struct packed {
		logic [SUM_W-1:0]   result;
		logic               borrow;
	} alu_rsp_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_MUL_HI,
		S_MUL_LO,
		S_OWN_RD,
		S_OWN_NODE,
		S_OWN_LEFT,
		S_OWN_RIGHT,
		S_CHK_OWN,
		S_CHK_TOTAL,
		S_PATH_RD,
		S_PATH_WR,
		S_DIV,
		S_DESC_LEFT,
		S_DESC_CMP_L,
		S_DESC_NODE,
		S_DESC_DIFF,
		S_DESC_CMP_R,
		S_FINISH
	} state_t;

endpackage

FILE: hw/rtl/wst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module wst_ram #(
	parameter int WIDTH = 29,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/wst_alu.sv
// Shared add/subtract unit of the weighted sum-tree selector, with borrow out.
// Depends on wst_pkg.
`timescale 1ns / 1ps

module wst_alu (
	input  wst_pkg::alu_req_t req,
	output wst_pkg::alu_rsp_t rsp
);
	import wst_pkg::*;

	logic [SUM_W:0] diff;
	logic [SUM_W:0] total;

	// Both results are formed one bit wider so the borrow falls out of the top bit.
	assign diff  = {1'b0, req.a} - {1'b0, req.b};
	assign total = {1'b0, req.a} + {1'b0, req.b};

	always_comb begin
		rsp.borrow = diff[SUM_W];
		case (req.op)
			ALU_ADD: rsp.result = total[SUM_W-1:0];
			ALU_SUB: rsp.result = diff[SUM_W-1:0];
			default: rsp.result = total[SUM_W-1:0];
		endcase
	end

endmodule

FILE: hw/rtl/weighted_sum_tree_selector.sv
// Top level of the weighted sum-tree selector: sequencer, tree RAM and shared adder.
// Depends on wst_pkg, wst_ram and wst_alu.
`timescale 1ns / 1ps

// Weighted selection without replacement over a sum tree of ENTRIES nodes held in
// one RAM. Commands are taken one at a time; cmd_stall is high while a command is
// in progress, and a finished result waits in the output register so the next
// command can be taken meanwhile. All arithmetic runs on one 30-bit adder, and
// the tree RAM reads one node per cycle, so these two set the timing. Clear writes
// every node in turn. Load scales the weight when scaling is on, then reads the
// entry's own weight from its node and children, checks the entry and the total
// for overflow and adds the weight along the path to the root. A select on an
// empty tree, the unused command code and a load past the last entry go straight
// to the result. Select reduces the random word modulo the total bit by bit,
// descends the tree to the chosen entry, reads its own weight and subtracts it
// along the path to the root. A command also waits in its last cycle while the
// previous result is still stalled in the output register. After reset the RAM
// is cleared, and no command is taken while it is.
module weighted_sum_tree_selector #(
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration register.
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	// Command channel.
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  cmd,
	input  logic [5:0]  entry_index,
	input  logic [15:0] weight_value,
	input  logic [31:0] random_word,
	// Result channel.
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  status,
	output logic [5:0]  chosen_index,
	output logic [22:0] chosen_weight,
	output logic [28:0] remaining_total
);
	import wst_pkg::*;

	localparam int NIW = $clog2(ENTRIES);
	localparam int CW  = NIW + 2;

	state_t state_q, state_d;

	logic                 adjust_q;
	logic [NIW-1:0]       clr_q;
	logic                 res_valid_q;
	logic                 res_load;

	logic [CMD_W-1:0]     cmd_q;
	logic [NIW-1:0]       i_q;
	logic [NIW-1:0]       ch_q;
	logic [RAW_W-1:0]     raw_q;
	logic [WEIGHT_W-1:0]  w_q;
	logic [SUM_W-1:0]     tmp_q;
	logic [NODE_W-1:0]    s_q;
	logic [RND_W-1:0]     rnd_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NODE_W-1:0]    total_q;
	status_t              st_q;

	status_t              res_status_q;
	logic [IDX_W-1:0]     res_index_q;
	logic [WEIGHT_W-1:0]  res_weight_q;
	logic [NODE_W-1:0]    res_total_q;

	logic                 ram_we;
	logic [NIW-1:0]       ram_waddr;
	logic [NODE_W-1:0]    ram_wdata;
	logic [NIW-1:0]       ram_raddr;
	logic [NODE_W-1:0]    ram_rdata;

	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;

	logic [CW-1:0]        left_n;
	logic [CW-1:0]        right_n;
	logic                 left_ok;
	logic                 right_ok;
	logic [NIW-1:0]       parent_n;
	logic                 in_range;
	logic                 clr_last;
	logic                 div_last;
	logic [SUM_W-1:0]     trial;
	logic [SUM_W-1:0]     raw_ext;

	// Tree storage.
	wst_ram #(
		.WIDTH(NODE_W),
		.DEPTH(ENTRIES)
	) u_tree (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Shared add/subtract unit.
	wst_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	// Child and parent positions of the current node.
	assign left_n   = {1'b0, i_q, 1'b1};
	assign right_n  = left_n + CW'(1);
	assign left_ok  = left_n < CW'(ENTRIES);
	assign right_ok = right_n < CW'(ENTRIES);
	assign parent_n = (i_q - NIW'(1)) >> 1;

	assign in_range = int'(entry_index) < ENTRIES;
	assign clr_last = clr_q == NIW'(ENTRIES - 1);
	assign div_last = cnt_q == DIV_CNT_W'(RND_W - 1);
	assign trial    = {s_q, rnd_q[RND_W-1]};
	assign raw_ext  = SUM_W'(raw_q);

	// State register, configuration register, clear counter and result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			adjust_q    <= 1'b1;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				adjust_q <= cfg_wdata;
			end
			if (state_q == S_INIT || state_q == S_CLEAR) begin
				clr_q <= clr_q + NIW'(1);
			end else begin
				clr_q <= '0;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Next state, RAM control and adder operands.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = i_q;
		ram_wdata = '0;
		ram_raddr = i_q;
		alu_req   = '{op: ALU_ADD, a: '0, b: '0};
		res_load  = 1'b0;
		case (state_q)
			S_INIT, S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_last) begin
					state_d = (state_q == S_INIT) ? S_IDLE : S_FINISH;
				end
			end
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd)
						CMD_CLEAR: state_d = S_CLEAR;
						CMD_LOAD: begin
							if (!in_range) begin
								state_d = S_FINISH;
							end else if (adjust_q && weight_value != '0) begin
								state_d = S_MUL_HI;
							end else begin
								state_d = S_OWN_RD;
							end
						end
						CMD_SELECT: state_d = (total_q == '0) ? S_FINISH : S_DIV;
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_MUL_HI: begin
				alu_req = '{op: ALU_ADD, a: raw_ext << SCALE_SH_A, b: raw_ext << SCALE_SH_B};
				state_d = S_MUL_LO;
			end
			S_MUL_LO: begin
				alu_req = '{op: ALU_ADD, a: tmp_q, b: raw_ext << SCALE_SH_C};
				state_d = S_OWN_RD;
			end
			S_OWN_RD: begin
				state_d = S_OWN_NODE;
			end
			S_OWN_NODE: begin
				ram_raddr = left_n[NIW-1:0];
				state_d   = S_OWN_LEFT;
			end
			S_OWN_LEFT: begin
				alu_req   = '{op: ALU_SUB, a: tmp_q,
					b: left_ok ? SUM_W'(ram_rdata) : '0};
				ram_raddr = right_n[NIW-1:0];
				state_d   = S_OWN_RIGHT;
			end
			S_OWN_RIGHT: begin
				alu_req = '{op: ALU_SUB, a: tmp_q,
					b: right_ok ? SUM_W'(ram_rdata) : '0};
				state_d = (cmd_q == CMD_LOAD) ? S_CHK_OWN : S_PATH_RD;
			end
			S_CHK_OWN: begin
				alu_req = '{op: ALU_ADD, a: tmp_q, b: SUM_W'(w_q)};
				state_d = (alu_rsp.result[SUM_W-1:WEIGHT_W] != '0) ? S_FINISH : S_CHK_TOTAL;
			end
			S_CHK_TOTAL: begin
				alu_req = '{op: ALU_ADD, a: SUM_W'(total_q), b: SUM_W'(w_q)};
				state_d = alu_rsp.result[SUM_W-1] ? S_FINISH : S_PATH_RD;
			end
			S_PATH_RD: begin
				state_d = S_PATH_WR;
			end
			S_PATH_WR: begin
				alu_req = '{op: (cmd_q == CMD_LOAD) ? ALU_ADD : ALU_SUB,
					a: SUM_W'(ram_rdata), b: SUM_W'(w_q)};
				ram_we    = 1'b1;
				ram_wdata = alu_rsp.result[NODE_W-1:0];
				state_d   = (i_q == '0) ? S_FINISH : S_PATH_RD;
			end
			S_DIV: begin
				alu_req = '{op: ALU_SUB, a: trial, b: SUM_W'(total_q)};
				if (div_last) begin
					state_d = S_DESC_LEFT;
				end
			end
			S_DESC_LEFT: begin
				ram_raddr = left_n[NIW-1:0];
				state_d   = left_ok ? S_DESC_CMP_L : S_OWN_RD;
			end
			S_DESC_CMP_L: begin
				alu_req   = '{op: ALU_SUB, a: SUM_W'(s_q), b: SUM_W'(ram_rdata)};
				ram_raddr = right_n[NIW-1:0];
				if (alu_rsp.borrow) begin
					state_d = S_DESC_LEFT;
				end else if (right_ok) begin
					state_d = S_DESC_NODE;
				end else begin
					state_d = S_OWN_RD;
				end
			end
			S_DESC_NODE: begin
				state_d = S_DESC_DIFF;
			end
			S_DESC_DIFF: begin
				alu_req = '{op: ALU_SUB, a: SUM_W'(ram_rdata), b: tmp_q};
				state_d = S_DESC_CMP_R;
			end
			S_DESC_CMP_R: begin
				alu_req = '{op: ALU_SUB, a: SUM_W'(s_q), b: tmp_q};
				state_d = alu_rsp.borrow ? S_OWN_RD : S_DESC_LEFT;
			end
			S_FINISH: begin
				if (!res_valid_q || !res_stall) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_INIT, S_CLEAR: begin
				total_q <= '0;
			end
			S_IDLE: begin
				cmd_q <= cmd;
				i_q   <= (cmd == CMD_SELECT) ? '0 : NIW'(entry_index);
				raw_q <= weight_value;
				w_q   <= (adjust_q && weight_value == '0) ? WEIGHT_W'(1)
					: WEIGHT_W'(weight_value);
				rnd_q <= random_word;
				s_q   <= '0;
				cnt_q <= '0;
				st_q  <= (cmd == CMD_SELECT && total_q == '0) ? ST_EMPTY : ST_DONE;
			end
			S_MUL_HI: begin
				tmp_q <= alu_rsp.result;
			end
			S_MUL_LO: begin
				w_q <= alu_rsp.result[WEIGHT_W-1:0];
			end
			S_OWN_NODE: begin
				tmp_q <= SUM_W'(ram_rdata);
			end
			S_OWN_LEFT: begin
				tmp_q <= alu_rsp.result;
			end
			S_OWN_RIGHT: begin
				tmp_q <= alu_rsp.result;
				if (cmd_q != CMD_LOAD) begin
					w_q  <= alu_rsp.result[WEIGHT_W-1:0];
					ch_q <= i_q;
					st_q <= ST_SELECTED;
				end
			end
			S_PATH_WR: begin
				i_q <= parent_n;
				if (i_q == '0) begin
					total_q <= alu_rsp.result[NODE_W-1:0];
				end
			end
			S_DIV: begin
				// One restoring step of the modulo per cycle.
				s_q   <= alu_rsp.borrow ? trial[NODE_W-1:0] : alu_rsp.result[NODE_W-1:0];
				rnd_q <= rnd_q << 1;
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			S_DESC_CMP_L: begin
				if (alu_rsp.borrow) begin
					i_q <= left_n[NIW-1:0];
				end
			end
			S_DESC_NODE: begin
				tmp_q <= SUM_W'(ram_rdata);
			end
			S_DESC_DIFF: begin
				tmp_q <= alu_rsp.result;
			end
			S_DESC_CMP_R: begin
				if (!alu_rsp.borrow) begin
					s_q <= alu_rsp.result[NODE_W-1:0];
					i_q <= right_n[NIW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= st_q;
			res_index_q  <= (st_q == ST_SELECTED) ? IDX_W'(ch_q) : '0;
			res_weight_q <= (st_q == ST_SELECTED) ? w_q : '0;
			res_total_q  <= total_q;
		end
	end

	assign cmd_stall       = state_q != S_IDLE;
	assign res_valid       = res_valid_q;
	assign status          = res_status_q;
	assign chosen_index    = res_index_q;
	assign chosen_weight   = res_weight_q;
	assign remaining_total = res_total_q;

endmodule

FILE: hw/rtl/wst_checker.sv
// Port-level checker of the weighted sum-tree selector and its bind.
// Depends on wst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [1:0]  status,
	input logic [5:0]  chosen_index,
	input logic [22:0] chosen_weight,
	input logic [28:0] remaining_total
);
	import wst_pkg::*;

	// A stalled result beat keeps its contents.
	`WST_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(status) && $stable(chosen_index) && $stable(chosen_weight) && $stable(remaining_total), "stalled result beat changed")

	// Every command leaves the idle state, so the block stalls right after a beat.
	`WST_ASSERT_NEXT(a_busy_after_cmd, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall, "command channel ready right after a beat")

	// Only a selection reports an entry.
	`WST_ASSERT(a_no_entry, clk, arst_n, (res_valid && status != ST_SELECTED) |-> (chosen_index == '0 && chosen_weight == '0), "entry reported without a selection")

	// An empty tree reports a zero total.
	`WST_ASSERT(a_empty_total, clk, arst_n, (res_valid && status == ST_EMPTY) |-> (remaining_total == '0), "empty status with nonzero total")

endmodule

bind weighted_sum_tree_selector wst_checker u_wst_checker (.*);
